// ===== rtl/i2da_pkg.sv =====
//------------------------------------------------------------------------------
// i2da_pkg
// Shared types and constants for the integer to decimal ASCII formatter.
//------------------------------------------------------------------------------
package i2da_pkg;

   localparam int VALUE_WIDTH_DEF = 32;
   localparam int BCD_WIDTH       = 4;
   localparam int CHAR_WIDTH      = 8;

   localparam logic [CHAR_WIDTH-1:0] MINUS_CODE = 8'd45;
   localparam logic [CHAR_WIDTH-1:0] DIGIT_BASE = 8'd48;
   localparam logic [CHAR_WIDTH-1:0] DIGIT_TOP  = 8'd57;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONV,
      ST_SIGN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic clear;
      logic dabble;
      logic shift;
   } cell_ctl_type;

endpackage

// ===== rtl/int_to_decimal_ascii_core.sv =====
//------------------------------------------------------------------------------
// int_to_decimal_ascii_core
// Formats a signed integer as decimal ASCII text, most significant first,
// with a leading '-' for negative values and a last flag on the final char.
//
//   channel | ports                          | direction
//   --------+--------------------------------+----------
//   req     | req_valid req_ready req_value  | in
//   rsp     | rsp_valid rsp_ready            | out
//           | rsp_char_code rsp_last         |
//
// A request passes through the accept, one double-dabble step per magnitude
// bit through the digit cell chain, the '-' character if negative, then the
// digit cells from the top (leading zeros are shifted past).
// A request is taken once the previous one's last character is in the output
// register.
// rsp_ready low with a character waiting stalls the sign and digit output;
// Reset is synchronous and clears the state machine and output valid.
//------------------------------------------------------------------------------
module int_to_decimal_ascii_core #(
   parameter int VALUE_WIDTH = i2da_pkg::VALUE_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [VALUE_WIDTH-1:0]       req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [i2da_pkg::CHAR_WIDTH-1:0]     rsp_char_code,
   output logic                                rsp_last
);

   localparam int NUM_DIGITS = ((VALUE_WIDTH - 1) * 30103) / 100000 + 1;
   localparam int CNT_W      = $clog2(VALUE_WIDTH + 1);
   localparam int REM_W      = $clog2(NUM_DIGITS + 1);
   localparam int BW         = i2da_pkg::BCD_WIDTH;
   localparam int CW         = i2da_pkg::CHAR_WIDTH;

   i2da_pkg::state_type    state_ff, state_in;
   i2da_pkg::cell_ctl_type cell_ctl;

   logic [VALUE_WIDTH-1:0] mag_ff, mag_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [REM_W-1:0]       remain_ff, remain_in;
   logic                   neg_ff, neg_in;
   logic                   lead_ff, lead_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]          rsp_char_ff, rsp_char_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic                   accept;
   logic                   slot_free;
   logic                   out_load;
   logic [CW-1:0]          out_code;
   logic                   out_last;
   logic [VALUE_WIDTH-1:0] abs_value;

   logic [NUM_DIGITS:0]    chain_bit;
   logic [BW-1:0]          chain_digit [NUM_DIGITS+1];
   logic [BW-1:0]          top_digit;

   // digit cell chain
   assign chain_bit[0]   = mag_ff[VALUE_WIDTH-1];
   assign chain_digit[0] = '0;
   assign top_digit      = chain_digit[NUM_DIGITS];

   for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
      i2da_cell u_cell (
         .clock    (clock),
         .ctl      (cell_ctl),
         .bit_in   (chain_bit[i]),
         .digit_in (chain_digit[i]),
         .bit_out  (chain_bit[i+1]),
         .digit    (chain_digit[i+1])
      );
   end

   assign req_ready     = (state_ff == i2da_pkg::ST_IDLE);
   assign accept        = req_valid & req_ready;
   assign slot_free     = ~rsp_valid_ff | rsp_ready;
   assign abs_value     = req_value[VALUE_WIDTH-1] ?
                          ~req_value + VALUE_WIDTH'(1) : req_value;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_char_code = rsp_char_ff;
   assign rsp_last      = rsp_last_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         i2da_pkg::ST_IDLE: begin
            if (req_valid) state_in = i2da_pkg::ST_CONV;
         end
         i2da_pkg::ST_CONV: begin
            if (count_ff == CNT_W'(1)) begin
               state_in = neg_ff ? i2da_pkg::ST_SIGN : i2da_pkg::ST_EMIT;
            end
         end
         i2da_pkg::ST_SIGN: begin
            if (slot_free) state_in = i2da_pkg::ST_EMIT;
         end
         i2da_pkg::ST_EMIT: begin
            if (out_load && out_last) state_in = i2da_pkg::ST_IDLE;
         end
         default: state_in = i2da_pkg::ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      cell_ctl = '0;
      out_load = 1'b0;
      out_code = i2da_pkg::MINUS_CODE;
      out_last = 1'b0;
      unique case (state_ff)
         i2da_pkg::ST_IDLE: begin
            cell_ctl.clear = req_valid;
         end
         i2da_pkg::ST_CONV: begin
            cell_ctl.dabble = 1'b1;
         end
         i2da_pkg::ST_SIGN: begin
            out_load = slot_free;
         end
         i2da_pkg::ST_EMIT: begin
            out_code = i2da_pkg::DIGIT_BASE + CW'(top_digit);
            out_last = (remain_ff == REM_W'(1));
            if (lead_ff && top_digit == '0 && !out_last) begin
               cell_ctl.shift = 1'b1;
            end else begin
               out_load       = slot_free;
               cell_ctl.shift = slot_free;
            end
         end
         default: begin
         end
      endcase
   end

   // datapath next values
   always_comb begin
      mag_in    = mag_ff;
      count_in  = count_ff;
      neg_in    = neg_ff;
      remain_in = remain_ff;
      lead_in   = lead_ff;
      if (accept) begin
         mag_in    = abs_value;
         count_in  = CNT_W'(VALUE_WIDTH);
         neg_in    = req_value[VALUE_WIDTH-1];
         remain_in = REM_W'(NUM_DIGITS);
         lead_in   = 1'b1;
      end else if (state_ff == i2da_pkg::ST_CONV) begin
         mag_in   = mag_ff << 1;
         count_in = count_ff - CNT_W'(1);
      end else if (cell_ctl.shift) begin
         remain_in = remain_ff - REM_W'(1);
         if (out_load) lead_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = out_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
      rsp_char_in  = out_load ? out_code : rsp_char_ff;
      rsp_last_in  = out_load ? out_last : rsp_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= i2da_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff      <= mag_in;
      count_ff    <= count_in;
      neg_ff      <= neg_in;
      remain_ff   <= remain_in;
      lead_ff     <= lead_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   // checks
   a_no_bcd_overflow: assert property (@(posedge clock) disable iff (reset)
      state_ff == i2da_pkg::ST_CONV |-> !chain_bit[NUM_DIGITS])
      else $error("digit chain overflow");

   a_top_digit_bcd: assert property (@(posedge clock) disable iff (reset)
      state_ff == i2da_pkg::ST_EMIT |-> top_digit <= 4'd9)
      else $error("invalid BCD digit at chain top");

   a_remain_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == i2da_pkg::ST_EMIT |-> remain_ff != '0)
      else $error("emit with no digits left");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      out_load && out_last |=> state_ff == i2da_pkg::ST_IDLE && rsp_last_ff)
      else $error("last character did not end the request");

   a_char_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_char_ff == i2da_pkg::MINUS_CODE ||
                        (rsp_char_ff >= i2da_pkg::DIGIT_BASE &&
                         rsp_char_ff <= i2da_pkg::DIGIT_TOP)))
      else $error("illegal character code");

endmodule

// ===== rtl/i2da_cell.sv =====
//------------------------------------------------------------------------------
// i2da_cell
// One BCD digit of the conversion chain: add-3 and shift while converting,
// digit handoff toward the top while emitting.
//------------------------------------------------------------------------------
module i2da_cell (
   input  logic                               clock,
   input  i2da_pkg::cell_ctl_type             ctl,
   input  logic                               bit_in,
   input  logic [i2da_pkg::BCD_WIDTH-1:0]     digit_in,
   output logic                               bit_out,
   output logic [i2da_pkg::BCD_WIDTH-1:0]     digit
);

   logic [i2da_pkg::BCD_WIDTH-1:0] digit_ff;
   logic [i2da_pkg::BCD_WIDTH-1:0] digit_in_nx;
   logic [i2da_pkg::BCD_WIDTH-1:0] adj;

   assign adj     = (digit_ff >= 4'd5) ? digit_ff + 4'd3 : digit_ff;
   assign bit_out = adj[i2da_pkg::BCD_WIDTH-1];
   assign digit   = digit_ff;

   always_comb begin
      if (ctl.clear) begin
         digit_in_nx = '0;
      end else if (ctl.dabble) begin
         digit_in_nx = {adj[i2da_pkg::BCD_WIDTH-2:0], bit_in};
      end else if (ctl.shift) begin
         digit_in_nx = digit_in;
      end else begin
         digit_in_nx = digit_ff;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in_nx;
   end

endmodule
